### src/ffca_pkg.sv
// ----------------------------------------------------------------------------
// ffca_pkg
// Shared types and constants of the first-fit contiguous slot allocator.
// ----------------------------------------------------------------------------
package ffca_pkg;

	localparam int WORD_W     = 32;
	localparam int WORD_LOG   = 5;
	localparam int CNT_W      = WORD_LOG + 1;
	localparam int FIELD_W    = 11;
	localparam int FIELD_MAX  = 2047;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 16;

	localparam logic [FIELD_W-1:0] SLOT_COUNT_RST = 11'd1024;

	localparam logic CMD_ALLOC   = 1'b0;
	localparam logic CMD_RELEASE = 1'b1;

	typedef struct packed {
		logic                 found;
		logic [WORD_LOG-1:0]  pos;
		logic [FIELD_W-1:0]   run_out;
	} scan_res_t;

endpackage

### src/ffca_ram.sv
// ----------------------------------------------------------------------------
// ffca_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ffca_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/ffca_scan.sv
// ----------------------------------------------------------------------------
// ffca_scan
// Run search over one 32-slot word of the free map, carrying the free run
// that ends at the previous word.
// ----------------------------------------------------------------------------
module ffca_scan import ffca_pkg::*; (
	input  logic [WORD_W-1:0]  free_word,
	input  logic [FIELD_W-1:0] run_in,
	input  logic [FIELD_W-1:0] len,
	output scan_res_t          res
);

	logic [WORD_W-1:0]   span;
	logic [WORD_W-1:0]   win;
	logic [WORD_LOG-1:0] len_m1;
	logic [CNT_W-1:0]    tail_ones;
	logic [CNT_W-1:0]    lead_ones;
	logic [WORD_LOG-1:0] first_hit;
	logic [FIELD_W-1:0]  need;
	logic                hit_prefix;
	logic                hit_inside;

	assign len_m1 = WORD_LOG'(len - 11'd1);
	assign need   = len - run_in;

	// win bit i: the len slots ending at bit i are all free
	always_comb begin
		span = free_word;
		win  = free_word;
		for (int b = 0; b < WORD_LOG; b++) begin
			if (len_m1[b]) begin
				win = span & (win << (1 << b));
			end
			span = span & (span << (1 << b));
		end
	end

	always_comb begin
		tail_ones = CNT_W'(WORD_W);
		lead_ones = CNT_W'(WORD_W);
		first_hit = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!free_word[i]) begin
				tail_ones = CNT_W'(i);
			end
			if (win[i]) begin
				first_hit = WORD_LOG'(i);
			end
		end
		for (int i = 0; i < WORD_W; i++) begin
			if (!free_word[i]) begin
				lead_ones = CNT_W'(WORD_W - 1 - i);
			end
		end
	end

	// carried run completed by the low bits of this word
	assign hit_prefix = (need <= FIELD_W'(WORD_W)) && (FIELD_W'(tail_ones) >= need);
	assign hit_inside = (len <= FIELD_W'(WORD_W)) && (len != '0) && (|win);

	assign res.found   = hit_prefix || hit_inside;
	assign res.pos     = hit_prefix ? WORD_LOG'(need - 11'd1) : first_hit;
	assign res.run_out = (&free_word) ? (run_in + FIELD_W'(WORD_W)) : FIELD_W'(lead_ones);

endmodule

### src/first_fit_contiguous_allocator_unit.sv
// ----------------------------------------------------------------------------
// first_fit_contiguous_allocator_unit
// First-fit allocator of contiguous slot runs over an occupancy bitmap.
// ----------------------------------------------------------------------------
// The map is held in a RAM of 32-slot words. After reset a clearing pass
// writes one word a cycle, ceil(min(SLOTS,2047)/32) words (32 for 1024
// slots), with s_axis_tready low. An allocate scans one word per cycle
// through a single run-search unit, from slot 1 up to the first fitting run
// or to the end of slot_count (clipped to min(SLOTS,2047)). A found run is
// then marked with one read-modify-write per word it spans, and ST_RESULT
// then posts the result. Without a fitting run the result is posted once the
// scan reaches the end, and a zero length or a zero slot_count goes straight
// to ST_RESULT with no scan. A result word still waiting on m_axis_tready holds
// the next result back. A release clears its run with the same per-word
// read-modify-write while busy and gives no result word. One item is worked
// on at a time; slot_count must be written only while the block is idle,
// and the block itself does not enforce this.
module first_fit_contiguous_allocator_unit import ffca_pkg::*; #(
	parameter int SLOTS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [FIELD_W-1:0]    cfg_data,      // slot_count
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // run_length [10:0], release_start [21:11]
	input  logic [0:0]            s_axis_tuser,  // cmd [0]
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata   // alloc_start [10:0]
);

	localparam int SLOT_LIM = (SLOTS < FIELD_MAX) ? SLOTS : FIELD_MAX;
	localparam int ROWS     = (SLOT_LIM + WORD_W - 1) / WORD_W;
	localparam int AW       = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int KW       = $clog2(ROWS + 1);

	localparam logic [FIELD_W-1:0] SLOT_LIM_V = FIELD_W'(SLOT_LIM);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_UPD,
		ST_RESULT
	} state_t;

	state_t              state_q;
	logic [AW-1:0]       clr_k_q;
	logic [FIELD_W-1:0]  slot_count_q;
	logic [KW-1:0]       rd_k_q;
	logic                ev_v_s1;
	logic [AW-1:0]       ev_k_s1;
	logic [FIELD_W-1:0]  len_q;
	logic [FIELD_W-1:0]  run_q;
	logic [FIELD_W-1:0]  lo_q;
	logic [FIELD_W-1:0]  hi_q;
	logic [FIELD_W-1:0]  res_q;
	logic                set_q;
	logic                m_valid_q;
	logic [FIELD_W-1:0]  m_data_q;

	logic [FIELD_W-1:0]  eff;
	logic [KW-1:0]       n_full;
	logic [KW-1:0]       n_words;
	logic [KW-1:0]       rd_lim;
	logic                issue;
	logic                scan_hit;
	logic                post_res;
	logic                in_cmd;
	logic [FIELD_W-1:0]  in_len;
	logic [FIELD_W-1:0]  in_start;
	logic [FIELD_W-1:0]  rel_lo;
	logic [FIELD_W:0]    rel_end;
	logic [FIELD_W-1:0]  rel_hi;
	logic                rel_ok;
	logic [WORD_W-1:0]   vmask;
	logic [WORD_W-1:0]   free_word;
	scan_res_t           scan_r;
	logic [FIELD_W-1:0]  g_end;
	logic [FIELD_W-1:0]  run_lo;
	logic [AW-1:0]       lo_w;
	logic [AW-1:0]       hi_w;
	logic [WORD_LOG-1:0] lo_off;
	logic [WORD_LOG-1:0] hi_off;
	logic [WORD_W-1:0]   umask;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [WORD_W-1:0]   ram_wdata;
	logic [WORD_W-1:0]   ram_rdata;

	assign eff     = (slot_count_q > SLOT_LIM_V) ? SLOT_LIM_V : slot_count_q;
	assign n_full  = KW'(eff >> WORD_LOG);
	assign n_words = n_full + KW'(|eff[WORD_LOG-1:0]);

	assign in_cmd   = s_axis_tuser[0];
	assign in_len   = s_axis_tdata[FIELD_W-1:0];
	assign in_start = s_axis_tdata[2*FIELD_W-1:FIELD_W];

	// release range clipped to 1..eff
	assign rel_lo  = (in_start == '0) ? 11'd1 : in_start;
	assign rel_end = {1'b0, in_start} + {1'b0, in_len} - 12'd1;
	assign rel_hi  = (rel_end > {1'b0, eff}) ? eff : rel_end[FIELD_W-1:0];
	assign rel_ok  = (in_len != '0) && (rel_lo <= rel_hi);

	assign rd_lim = (state_q == ST_SCAN) ? n_words : (KW'(hi_q >> WORD_LOG) + KW'(1));
	assign issue  = ((state_q == ST_SCAN) || (state_q == ST_UPD)) && (rd_k_q < rd_lim);

	assign scan_hit = (state_q == ST_SCAN) && ev_v_s1 && scan_r.found;
	assign post_res = (state_q == ST_RESULT) && (!m_valid_q || m_axis_tready);

	// slots past the count read as used
	assign vmask     = (KW'(ev_k_s1) < n_full) ? '1 : ~({WORD_W{1'b1}} << eff[WORD_LOG-1:0]);
	assign free_word = ~ram_rdata & vmask;

	ffca_scan u_scan (
		.free_word (free_word),
		.run_in    (run_q),
		.len       (len_q),
		.res       (scan_r)
	);

	assign g_end  = (FIELD_W'(ev_k_s1) << WORD_LOG) | FIELD_W'(scan_r.pos);
	assign run_lo = g_end + 11'd1 - len_q;

	assign lo_w   = AW'(lo_q >> WORD_LOG);
	assign hi_w   = AW'(hi_q >> WORD_LOG);
	assign lo_off = (ev_k_s1 == lo_w) ? lo_q[WORD_LOG-1:0] : '0;
	assign hi_off = (ev_k_s1 == hi_w) ? hi_q[WORD_LOG-1:0] : '1;
	assign umask  = ({WORD_W{1'b1}} << lo_off) & ({WORD_W{1'b1}} >> (5'd31 - hi_off));

	assign ram_we    = (state_q == ST_CLEAR) || ((state_q == ST_UPD) && ev_v_s1);
	assign ram_waddr = (state_q == ST_CLEAR) ? clr_k_q : ev_k_s1;
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 :
		(set_q ? (ram_rdata | umask) : (ram_rdata & ~umask));

	ffca_ram #(
		.WIDTH (WORD_W),
		.DEPTH (ROWS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (issue),
		.raddr (rd_k_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_k_q      <= '0;
			slot_count_q <= SLOT_COUNT_RST;
			rd_k_q       <= '0;
			ev_v_s1      <= 1'b0;
			ev_k_s1      <= '0;
			len_q        <= '0;
			run_q        <= '0;
			lo_q         <= '0;
			hi_q         <= '0;
			res_q        <= '0;
			set_q        <= 1'b0;
			m_valid_q    <= 1'b0;
			m_data_q     <= '0;
		end else begin
			if (cfg_valid) begin
				slot_count_q <= cfg_data;
			end
			if (post_res) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			// drop the scan read in flight once a run is found
			ev_v_s1 <= issue && !scan_hit;
			ev_k_s1 <= rd_k_q[AW-1:0];
			if (issue && !scan_hit) begin
				rd_k_q <= rd_k_q + KW'(1);
			end
			case (state_q)
				ST_CLEAR: begin
					clr_k_q <= clr_k_q + AW'(1);
					if (clr_k_q == AW'(ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						len_q  <= in_len;
						run_q  <= '0;
						res_q  <= '0;
						if (in_cmd == CMD_ALLOC) begin
							set_q  <= 1'b1;
							rd_k_q <= '0;
							if ((in_len == '0) || (eff == '0)) begin
								state_q <= ST_RESULT;
							end else begin
								state_q <= ST_SCAN;
							end
						end else if (rel_ok) begin
							set_q   <= 1'b0;
							lo_q    <= rel_lo - 11'd1;
							hi_q    <= rel_hi - 11'd1;
							rd_k_q  <= KW'((rel_lo - 11'd1) >> WORD_LOG);
							state_q <= ST_UPD;
						end
					end
				end
				ST_SCAN: begin
					if (ev_v_s1) begin
						if (scan_r.found) begin
							lo_q    <= run_lo;
							hi_q    <= g_end;
							res_q   <= run_lo + 11'd1;
							rd_k_q  <= KW'(run_lo >> WORD_LOG);
							state_q <= ST_UPD;
						end else begin
							run_q <= scan_r.run_out;
							if (KW'(ev_k_s1) == (n_words - KW'(1))) begin
								state_q <= ST_RESULT;
							end
						end
					end
				end
				ST_UPD: begin
					if (ev_v_s1 && (ev_k_s1 == hi_w)) begin
						state_q <= set_q ? ST_RESULT : ST_IDLE;
					end
				end
				ST_RESULT: begin
					if (post_res) begin
						m_data_q <= res_q;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - FIELD_W){1'b0}}, m_data_q};

endmodule

### src/ffca_checker.sv
// ----------------------------------------------------------------------------
// ffca_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffca_checker import ffca_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_axis_tvalid,
	input logic                  s_axis_tready,
	input logic [0:0]            s_axis_tuser,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic in_acc;

	assign in_acc = s_axis_tvalid && s_axis_tready;

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// slot numbers use the low 11 bits only
	a_out_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[OUT_DATA_W-1:FIELD_W] == '0))
		else $error("result padding not zero");

	// an allocate always keeps the block busy for the next cycle
	a_alloc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && (s_axis_tuser[0] == CMD_ALLOC) |=> !s_axis_tready)
		else $error("ready right after allocate");

	// a result never appears in the cycle right after an item is taken
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !$rose(m_axis_tvalid))
		else $error("result too early");

endmodule

bind first_fit_contiguous_allocator_unit ffca_checker u_ffca_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### test/first_fit_contiguous_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// first_fit_contiguous_allocator_unit_tb
// Self-checking bench for the first-fit slot allocator. A directed table
// walks the edge cases, then a dozen random phases under different
// slot_count settings and idle patterns. Each allocate word is checked
// in order against the result stream, expected either from the table or
// as predicted on a local copy of the occupancy map.
// ----------------------------------------------------------------------------
module first_fit_contiguous_allocator_unit_tb;
	import ffca_pkg::*;

	localparam int SLOTS        = 1024;
	localparam int DRAIN_CYCLES = 64;
	localparam int PHASE_WORDS  = 100;
	localparam int PHASES       = 12;
	localparam int DIRECTED     = 24;
	localparam logic KNOWN      = 1'b1;
	localparam logic PREDICTED  = 1'b0;

	typedef struct packed {
		logic               cmd;
		logic [FIELD_W-1:0] len;
		logic [FIELD_W-1:0] first;
		logic               known;
		logic [FIELD_W-1:0] want;
	} step_row_t;

	typedef struct packed {
		logic [FIELD_W-1:0] first;
		logic [FIELD_W-1:0] len;
	} run_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [FIELD_W-1:0]    cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [0:0]            s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;

	bit                 occupied [1:SLOTS];
	logic [FIELD_W-1:0] slot_setting = SLOT_COUNT_RST;
	logic [FIELD_W-1:0] alloc_start_q [$];
	run_t               held_runs [$];
	step_row_t          directed_rows [DIRECTED];
	logic [FIELD_W-1:0] phase_slots [PHASES];
	int                 err_count    = 0;
	int                 src_idle_pct = 18;
	int                 snk_idle_pct = 77;

	first_fit_contiguous_allocator_unit #(.SLOTS(SLOTS)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 1_000_000);
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int live_slots();
		return (slot_setting > SLOTS) ? SLOTS : int'(slot_setting);
	endfunction

	// leftmost run of len free slots, marked used
	function automatic logic [FIELD_W-1:0] claim_first_fit(input logic [FIELD_W-1:0] len);
		int lim;
		int run;
		int s;
		int k;
		lim = live_slots();
		run = 0;
		if (len == 0)
			return '0;
		for (s = 1; s <= lim; s++) begin
			if (occupied[s]) begin
				run = 0;
			end else begin
				run++;
				if (run == int'(len)) begin
					for (k = s - run + 1; k <= s; k++)
						occupied[k] = 1'b1;
					return FIELD_W'(s - run + 1);
				end
			end
		end
		return '0;
	endfunction

	function automatic void free_range(input logic [FIELD_W-1:0] first,
					   input logic [FIELD_W-1:0] len);
		int lo;
		int hi;
		int k;
		if (len == 0)
			return;
		lo = (first < 1) ? 1 : int'(first);
		hi = int'(first) + int'(len) - 1;
		if (hi > live_slots())
			hi = live_slots();
		for (k = lo; k <= hi; k++)
			occupied[k] = 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
				       input logic [FIELD_W-1:0] want);
		$display("mismatch: %s, got %0d want %0d at %0t", what, got, want, $time);
		err_count++;
	endtask

	// leaves tvalid high; callers lower it when the stream pauses
	task automatic send_word(input logic cmd, input logic [FIELD_W-1:0] len,
				 input logic [FIELD_W-1:0] first, input logic known,
				 input logic [FIELD_W-1:0] want);
		logic [FIELD_W-1:0] granted;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {2'b00, first, len};
		do @(posedge clk); while (!s_axis_tready);
		if (cmd == CMD_ALLOC) begin
			granted = claim_first_fit(len);
			alloc_start_q.push_back(known ? want : granted);
			if (granted != 0)
				held_runs.push_back('{granted, len});
		end else begin
			free_range(first, len);
		end
	endtask

	task automatic hold_off(input int cycles);
		s_axis_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic wait_results_done();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (alloc_start_q.size() != 0);
	endtask

	task automatic write_slot_count(input logic [FIELD_W-1:0] value);
		wait_results_done();
		// a release gives no word, so let one finish before the write
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		slot_setting = value;
	endtask

	task automatic sender_gap();
		int gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct)
			gap++;
		if (gap > 0)
			hold_off(gap);
	endtask

	task automatic random_word();
		int                 r;
		int                 pick;
		logic [FIELD_W-1:0] len;
		logic [FIELD_W-1:0] first;
		r    = $urandom_range(99);
		pick = $urandom_range(99);
		if (r < 52) begin
			if (pick < 65)
				len = FIELD_W'($urandom_range(1, 16));
			else if (pick < 88)
				len = FIELD_W'($urandom_range(17, 128));
			else if (pick < 97)
				len = FIELD_W'($urandom_range(129, 1024));
			else
				len = FIELD_W'($urandom_range(0, 2047));
			send_word(CMD_ALLOC, len, FIELD_W'($urandom_range(0, 2047)), PREDICTED, '0);
		end else if (r < 90 && held_runs.size() != 0) begin
			pick  = $urandom_range(0, held_runs.size() - 1);
			first = held_runs[pick].first;
			len   = held_runs[pick].len;
			held_runs.delete(pick);
			send_word(CMD_RELEASE, len, first, PREDICTED, '0);
		end else if (r < 93) begin
			held_runs.delete();
			send_word(CMD_RELEASE, 11'd2047, 11'd1, PREDICTED, '0);
		end else begin
			// stray release, often overlapping or past the end
			first = (pick < 50) ? FIELD_W'($urandom_range(0, 64)) :
				FIELD_W'($urandom_range(0, 2047));
			len   = (pick < 30) ? FIELD_W'($urandom_range(0, 2047)) :
				FIELD_W'($urandom_range(0, 40));
			send_word(CMD_RELEASE, len, first, PREDICTED, '0);
		end
	endtask

	always @(posedge clk) begin : result_check
		logic [FIELD_W-1:0] want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (alloc_start_q.size() == 0) begin
				report_mismatch("alloc_start with nothing pending",
						m_axis_tdata[FIELD_W-1:0], '0);
			end else begin
				want = alloc_start_q.pop_front();
				if (m_axis_tdata[FIELD_W-1:0] !== want)
					report_mismatch("alloc_start", m_axis_tdata[FIELD_W-1:0], want);
			end
		end
		m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	initial begin
		directed_rows = '{
			'{CMD_ALLOC,   11'd1,    11'd0,    KNOWN,     11'd1},
			'{CMD_ALLOC,   11'd0,    11'd5,    KNOWN,     11'd0},
			'{CMD_ALLOC,   11'd2047, 11'd2047, KNOWN,     11'd0},
			'{CMD_ALLOC,   11'd1024, 11'd0,    KNOWN,     11'd0},
			'{CMD_RELEASE, 11'd1,    11'd1,    PREDICTED, 11'd0},
			'{CMD_ALLOC,   11'd1024, 11'd1024, KNOWN,     11'd1},
			'{CMD_ALLOC,   11'd1,    11'd0,    KNOWN,     11'd0},
			'{CMD_RELEASE, 11'd2047, 11'd0,    PREDICTED, 11'd0},
			'{CMD_ALLOC,   11'd5,    11'd0,    PREDICTED, 11'd0},
			'{CMD_ALLOC,   11'd3,    11'd0,    PREDICTED, 11'd0},
			'{CMD_RELEASE, 11'd2,    11'd2,    PREDICTED, 11'd0},
			'{CMD_ALLOC,   11'd3,    11'd0,    PREDICTED, 11'd0},
			'{CMD_ALLOC,   11'd2,    11'd0,    PREDICTED, 11'd0},
			'{CMD_RELEASE, 11'd2047, 11'd2047, PREDICTED, 11'd0},
			'{CMD_RELEASE, 11'd0,    11'd1,    PREDICTED, 11'd0},
			'{CMD_RELEASE, 11'd1,    11'd0,    PREDICTED, 11'd0},
			'{CMD_ALLOC,   11'd1,    11'd0,    PREDICTED, 11'd0},
			'{CMD_ALLOC,   11'd1013, 11'd0,    PREDICTED, 11'd0},
			'{CMD_RELEASE, 11'd10,   11'd1020, PREDICTED, 11'd0},
			'{CMD_ALLOC,   11'd5,    11'd0,    PREDICTED, 11'd0},
			'{CMD_RELEASE, 11'd1,    11'd1024, PREDICTED, 11'd0},
			'{CMD_ALLOC,   11'd2,    11'd0,    PREDICTED, 11'd0},
			'{CMD_ALLOC,   11'd1,    11'd0,    PREDICTED, 11'd0},
			'{CMD_RELEASE, 11'd2047, 11'd1,    PREDICTED, 11'd0}
		};
		phase_slots = '{11'd1, 11'd0, 11'd2047, 11'd64, 11'd1000, 11'd2,
				11'd333, 11'd1023, 11'd96, 11'd1025, 11'd1024, 11'd1};
		phase_slots[PHASES-1] = FIELD_W'($urandom_range(1, 1024));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED; i++) begin
			sender_gap();
			send_word(directed_rows[i].cmd, directed_rows[i].len, directed_rows[i].first,
				  directed_rows[i].known, directed_rows[i].want);
		end
		wait_results_done();
		held_runs.delete();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 4) begin
				src_idle_pct = 77;
				snk_idle_pct = 18;
			end else if (p == 8) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			write_slot_count(phase_slots[p]);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				sender_gap();
				random_word();
				if ((p == 1 && n == 50) || $urandom_range(199) == 0)
					wait_results_done();
			end
		end

		wait_results_done();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && alloc_start_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
